// File: rtl/core/tpld_pkg.sv
// shared types, constants and codes for the two-plane line draw engine
// no dependencies; used by tpld_ctrl, tpld_datapath and the top level
package tpld_pkg;

   // display geometry and coordinate width
   localparam int DISPLAY_WIDTH  = 800;
   localparam int DISPLAY_HEIGHT = 480;
   localparam int COORD_BITS     = 12;

   // bits per plane byte, and the shift from pixel position to byte index
   localparam int BYTE_BITS  = 8;
   localparam int BYTE_SHIFT = 3;

   localparam int PLANE_BYTES = (DISPLAY_WIDTH * DISPLAY_HEIGHT + BYTE_BITS - 1) / BYTE_BITS;
   localparam int ADDR_BITS   = (PLANE_BYTES > 1) ? $clog2(PLANE_BYTES) : 1;
   localparam int POS_BITS    = $clog2(DISPLAY_WIDTH * DISPLAY_HEIGHT);
   localparam int XPOS_BITS   = $clog2(DISPLAY_WIDTH);
   localparam int YPOS_BITS   = (DISPLAY_HEIGHT > 1) ? $clog2(DISPLAY_HEIGHT) : 1;

   // internal coordinate width: room for differences and the error term
   localparam int LW = COORD_BITS + 2;

   typedef logic signed [LW-1:0] coord_type;
   typedef logic [ADDR_BITS-1:0] addr_type;

   // request actions
   localparam logic [2:0] ACT_LINE  = 3'd0;
   localparam logic [2:0] ACT_RECT  = 3'd1;
   localparam logic [2:0] ACT_FILL  = 3'd2;
   localparam logic [2:0] ACT_CLEAR = 3'd3;
   localparam logic [2:0] ACT_READ  = 3'd4;

   // ink codes, anything else is white
   localparam logic [1:0] INK_BLACK = 2'd1;
   localparam logic [1:0] INK_RED   = 2'd2;

   typedef struct packed {
      logic [2:0]                   action;
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
      logic [1:0]                   ink;
      logic [15:0]                  read_index;
   } req_type;

   // also the layout of one plane memory word
   typedef struct packed {
      logic [BYTE_BITS-1:0] black_byte;
      logic [BYTE_BITS-1:0] red_byte;
   } rsp_type;

   // where the current line's endpoints come from
   typedef enum logic [2:0] {
      SRC_DIRECT,
      SRC_EDGE0,
      SRC_EDGE1,
      SRC_EDGE2,
      SRC_EDGE3,
      SRC_ROW
   } src_type;

   typedef struct packed {
      logic    take_req;
      logic    load_line;
      logic    calc_abs;
      logic    calc_steep;
      logic    calc_order;
      logic    step;
      logic    fill_init;
      logic    next_row;
      logic    clear_wr;
      logic    rsp_load;
      src_type src;
   } cmd_type;

   typedef struct packed {
      logic run_last;
      logic pipe_idle;
      logic clear_last;
      logic fill_empty;
      logic fill_last_row;
      logic rsp_free;
   } sts_type;

endpackage

// File: rtl/core/tpld_ctrl.sv
// command sequencer for the two-plane line draw engine
// depends on tpld_pkg; drives tpld_datapath through cmd_type, reads sts_type
module tpld_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [2:0]        req_action,
   output logic              req_ready,
   input  tpld_pkg::sts_type sts,
   output tpld_pkg::cmd_type cmd
);

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL_INIT,
      ST_FILL_CHECK,
      ST_LOAD,
      ST_ABS,
      ST_STEEP,
      ST_ORDER,
      ST_RUN,
      ST_DRAIN,
      ST_RD_ISSUE,
      ST_RD_WAIT
   } state_type;

   state_type         state_ff;
   tpld_pkg::src_type src_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         src_ff   <= tpld_pkg::SRC_DIRECT;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (sts.clear_last) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_valid) begin
                  priority case (req_action)
                     tpld_pkg::ACT_LINE: begin
                        src_ff   <= tpld_pkg::SRC_DIRECT;
                        state_ff <= ST_LOAD;
                     end
                     tpld_pkg::ACT_RECT: begin
                        src_ff   <= tpld_pkg::SRC_EDGE0;
                        state_ff <= ST_LOAD;
                     end
                     tpld_pkg::ACT_FILL:  state_ff <= ST_FILL_INIT;
                     tpld_pkg::ACT_CLEAR: state_ff <= ST_CLEAR;
                     tpld_pkg::ACT_READ:  state_ff <= ST_RD_ISSUE;
                     default:             state_ff <= ST_IDLE;
                  endcase
               end
            end
            ST_FILL_INIT: state_ff <= ST_FILL_CHECK;
            ST_FILL_CHECK: begin
               if (sts.fill_empty) begin
                  state_ff <= ST_DRAIN;
               end else begin
                  src_ff   <= tpld_pkg::SRC_ROW;
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD:  state_ff <= ST_ABS;
            ST_ABS:   state_ff <= ST_STEEP;
            ST_STEEP: state_ff <= ST_ORDER;
            ST_ORDER: state_ff <= ST_RUN;
            ST_RUN: begin
               if (sts.run_last) begin
                  unique case (src_ff)
                     tpld_pkg::SRC_EDGE0: begin
                        src_ff   <= tpld_pkg::SRC_EDGE1;
                        state_ff <= ST_LOAD;
                     end
                     tpld_pkg::SRC_EDGE1: begin
                        src_ff   <= tpld_pkg::SRC_EDGE2;
                        state_ff <= ST_LOAD;
                     end
                     tpld_pkg::SRC_EDGE2: begin
                        src_ff   <= tpld_pkg::SRC_EDGE3;
                        state_ff <= ST_LOAD;
                     end
                     tpld_pkg::SRC_ROW: begin
                        state_ff <= sts.fill_last_row ? ST_DRAIN : ST_LOAD;
                     end
                     default: state_ff <= ST_DRAIN;
                  endcase
               end
            end
            ST_DRAIN: begin
               if (sts.pipe_idle) state_ff <= ST_IDLE;
            end
            ST_RD_ISSUE: state_ff <= ST_RD_WAIT;
            ST_RD_WAIT: begin
               if (sts.rsp_free) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd            = '0;
      cmd.src        = src_ff;
      cmd.take_req   = (state_ff == ST_IDLE) && req_valid;
      cmd.load_line  = (state_ff == ST_LOAD);
      cmd.calc_abs   = (state_ff == ST_ABS);
      cmd.calc_steep = (state_ff == ST_STEEP);
      cmd.calc_order = (state_ff == ST_ORDER);
      cmd.step       = (state_ff == ST_RUN);
      cmd.fill_init  = (state_ff == ST_FILL_INIT);
      cmd.next_row   = (state_ff == ST_RUN) && sts.run_last
                       && (src_ff == tpld_pkg::SRC_ROW) && !sts.fill_last_row;
      cmd.clear_wr   = (state_ff == ST_CLEAR);
      cmd.rsp_load   = (state_ff == ST_RD_WAIT) && sts.rsp_free;
   end

endmodule

// File: rtl/core/tpld_datapath.sv
// line stepper, pixel pipeline and plane memory for the two-plane line draw engine
// depends on tpld_pkg; controlled by tpld_ctrl through cmd_type and sts_type
module tpld_datapath (
   input  logic              clock,
   input  logic              reset,
   input  tpld_pkg::req_type req_data,
   input  tpld_pkg::cmd_type cmd,
   output tpld_pkg::sts_type sts,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tpld_pkg::rsp_type rsp_data
);

   // latched request
   tpld_pkg::req_type req_ff;
   tpld_pkg::coord_type x0, y0, x1, y1;

   // line endpoints and setup
   tpld_pkg::coord_type sx, sy, ex, ey;
   tpld_pkg::coord_type lx0_ff, ly0_ff, lx1_ff, ly1_ff;
   tpld_pkg::coord_type adx_in, ady_in, adx_ff, ady_ff;
   tpld_pkg::coord_type su0_ff, sv0_ff, su1_ff, sv1_ff;
   logic                steep_ff;

   // stepper
   tpld_pkg::coord_type cu_ff, cv_ff, eu_ff, dmaj_ff, dmin_ff, err_ff;
   tpld_pkg::coord_type dmaj_in, err_m, cv_step;
   logic                up_ff, swap;

   // fill bounds
   tpld_pkg::coord_type fy_ff, fhi_ff, fxl_ff, fxh_ff;
   tpld_pkg::coord_type lo_c, hi_c, xl_c, xh_c;

   // pixel pipeline
   logic                         p1v_ff, p2v_ff, p3v_ff;
   tpld_pkg::coord_type          p1_x_ff, p1_y_ff;
   logic                         on_screen;
   logic [tpld_pkg::POS_BITS-1:0] pos;
   tpld_pkg::addr_type           p2_addr_ff, p3_addr_ff;
   logic [2:0]                   p2_bit_ff, p3_bit_ff;

   // memory and forwarding
   tpld_pkg::rsp_type  plane_mem [tpld_pkg::PLANE_BYTES];
   tpld_pkg::rsp_type  rd_ff, cur, wr_data, fwd_data_ff;
   tpld_pkg::addr_type rd_addr, wr_addr, fwd_addr_ff, clr_ff;
   logic               wr_en, fwd_v_ff;
   logic [tpld_pkg::BYTE_BITS-1:0] mask;

   // response
   logic              rsp_valid_ff, in_range;
   tpld_pkg::rsp_type rsp_ff;

   assign x0 = tpld_pkg::coord_type'(req_ff.start_x);
   assign y0 = tpld_pkg::coord_type'(req_ff.start_y);
   assign x1 = tpld_pkg::coord_type'(req_ff.end_x);
   assign y1 = tpld_pkg::coord_type'(req_ff.end_y);

   always_ff @(posedge clock) begin
      if (cmd.take_req) req_ff <= req_data;
   end

   // endpoint selection
   always_comb begin
      unique case (cmd.src)
         tpld_pkg::SRC_EDGE0: begin sx = x0;     sy = y0;    ex = x0;     ey = y1;    end
         tpld_pkg::SRC_EDGE1: begin sx = x0;     sy = y0;    ex = x1;     ey = y0;    end
         tpld_pkg::SRC_EDGE2: begin sx = x1;     sy = y1;    ex = x0;     ey = y1;    end
         tpld_pkg::SRC_EDGE3: begin sx = x1;     sy = y1;    ex = x1;     ey = y0;    end
         tpld_pkg::SRC_ROW:   begin sx = fxl_ff; sy = fy_ff; ex = fxh_ff; ey = fy_ff; end
         default:             begin sx = x0;     sy = y0;    ex = x1;     ey = y1;    end
      endcase
   end

   // line setup
   always_comb begin
      adx_in  = lx1_ff - lx0_ff;
      ady_in  = ly1_ff - ly0_ff;
      adx_in  = adx_in[tpld_pkg::LW-1] ? -adx_in : adx_in;
      ady_in  = ady_in[tpld_pkg::LW-1] ? -ady_in : ady_in;
      swap    = su0_ff > su1_ff;
      dmaj_in = steep_ff ? ady_ff : adx_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_line) begin
         lx0_ff <= sx;
         ly0_ff <= sy;
         lx1_ff <= ex;
         ly1_ff <= ey;
      end
      if (cmd.calc_abs) begin
         adx_ff <= adx_in;
         ady_ff <= ady_in;
      end
      if (cmd.calc_steep) begin
         steep_ff <= ady_ff > adx_ff;
         if (ady_ff > adx_ff) begin
            su0_ff <= ly0_ff; sv0_ff <= lx0_ff;
            su1_ff <= ly1_ff; sv1_ff <= lx1_ff;
         end else begin
            su0_ff <= lx0_ff; sv0_ff <= ly0_ff;
            su1_ff <= lx1_ff; sv1_ff <= ly1_ff;
         end
      end
      if (cmd.calc_order) begin
         dmaj_ff <= dmaj_in;
         dmin_ff <= steep_ff ? adx_ff : ady_ff;
         err_ff  <= dmaj_in >>> 1;
         if (swap) begin
            cu_ff <= su1_ff; cv_ff <= sv1_ff; eu_ff <= su0_ff;
            up_ff <= sv1_ff < sv0_ff;
         end else begin
            cu_ff <= su0_ff; cv_ff <= sv0_ff; eu_ff <= su1_ff;
            up_ff <= sv0_ff < sv1_ff;
         end
      end else if (cmd.step) begin
         cu_ff <= cu_ff + tpld_pkg::coord_type'(1);
         if (err_m[tpld_pkg::LW-1]) begin
            cv_ff  <= cv_ff + cv_step;
            err_ff <= err_m + dmaj_ff;
         end else begin
            err_ff <= err_m;
         end
      end
   end

   assign err_m   = err_ff - dmin_ff;
   assign cv_step = up_ff ? tpld_pkg::coord_type'(1) : tpld_pkg::coord_type'(-1);

   // fill bounds, clipped to the display
   always_comb begin
      lo_c = (y0 < y1) ? y0 : y1;
      hi_c = (y0 < y1) ? y1 : y0;
      xl_c = (x0 < x1) ? x0 : x1;
      xh_c = (x0 < x1) ? x1 : x0;
      if (lo_c[tpld_pkg::LW-1]) lo_c = '0;
      if (xl_c[tpld_pkg::LW-1]) xl_c = '0;
      if (hi_c > tpld_pkg::coord_type'(tpld_pkg::DISPLAY_HEIGHT - 1))
         hi_c = tpld_pkg::coord_type'(tpld_pkg::DISPLAY_HEIGHT - 1);
      if (xh_c > tpld_pkg::coord_type'(tpld_pkg::DISPLAY_WIDTH - 1))
         xh_c = tpld_pkg::coord_type'(tpld_pkg::DISPLAY_WIDTH - 1);
   end

   always_ff @(posedge clock) begin
      if (cmd.fill_init) begin
         fy_ff  <= lo_c;
         fhi_ff <= hi_c;
         fxl_ff <= xl_c;
         fxh_ff <= xh_c;
      end else if (cmd.next_row) begin
         fy_ff <= fy_ff + tpld_pkg::coord_type'(1);
      end
   end

   // pixel pipeline: coordinates, clip and byte index, read-modify-write
   assign on_screen = !p1_x_ff[tpld_pkg::LW-1] && !p1_y_ff[tpld_pkg::LW-1]
                      && (p1_x_ff < tpld_pkg::coord_type'(tpld_pkg::DISPLAY_WIDTH))
                      && (p1_y_ff < tpld_pkg::coord_type'(tpld_pkg::DISPLAY_HEIGHT));

   assign pos = tpld_pkg::POS_BITS'(p1_y_ff[tpld_pkg::YPOS_BITS-1:0])
                * tpld_pkg::POS_BITS'(tpld_pkg::DISPLAY_WIDTH)
                + tpld_pkg::POS_BITS'(p1_x_ff[tpld_pkg::XPOS_BITS-1:0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         p1v_ff   <= 1'b0;
         p2v_ff   <= 1'b0;
         p3v_ff   <= 1'b0;
         fwd_v_ff <= 1'b0;
      end else begin
         p1v_ff   <= cmd.step;
         p2v_ff   <= p1v_ff && on_screen;
         p3v_ff   <= p2v_ff;
         fwd_v_ff <= p3v_ff;
      end
      p1_x_ff     <= steep_ff ? cv_ff : cu_ff;
      p1_y_ff     <= steep_ff ? cu_ff : cv_ff;
      p2_addr_ff  <= tpld_pkg::ADDR_BITS'(pos >> tpld_pkg::BYTE_SHIFT);
      p2_bit_ff   <= p1_x_ff[2:0];
      p3_addr_ff  <= p2_addr_ff;
      p3_bit_ff   <= p2_bit_ff;
      fwd_addr_ff <= p3_addr_ff;
      fwd_data_ff <= wr_data;
   end

   // a write at the previous edge is not yet in the read data
   assign cur  = (fwd_v_ff && (fwd_addr_ff == p3_addr_ff)) ? fwd_data_ff : rd_ff;
   assign mask = {1'b1, {(tpld_pkg::BYTE_BITS - 1){1'b0}}} >> p3_bit_ff;

   always_comb begin
      if (cmd.clear_wr) begin
         wr_data = '0;
      end else begin
         priority if (req_ff.ink == tpld_pkg::INK_BLACK) begin
            wr_data.black_byte = cur.black_byte | mask;
            wr_data.red_byte   = cur.red_byte & ~mask;
         end else if (req_ff.ink == tpld_pkg::INK_RED) begin
            wr_data.black_byte = cur.black_byte | mask;
            wr_data.red_byte   = cur.red_byte | mask;
         end else begin
            wr_data.black_byte = cur.black_byte & ~mask;
            wr_data.red_byte   = cur.red_byte & ~mask;
         end
      end
   end

   assign wr_en   = cmd.clear_wr || p3v_ff;
   assign wr_addr = cmd.clear_wr ? clr_ff : p3_addr_ff;
   assign rd_addr = p2v_ff ? p2_addr_ff : tpld_pkg::ADDR_BITS'(req_ff.read_index);

   always_ff @(posedge clock) begin
      if (wr_en) plane_mem[wr_addr] <= wr_data;
      rd_ff <= plane_mem[rd_addr];
   end

   // clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_wr) begin
         clr_ff <= sts.clear_last ? '0 : clr_ff + tpld_pkg::addr_type'(1);
      end
   end

   // read-back result register
   assign in_range = {16'd0, req_ff.read_index} < 32'(tpld_pkg::PLANE_BYTES);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) rsp_ff <= in_range ? rd_ff : '0;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      sts.run_last      = (cu_ff == eu_ff);
      sts.pipe_idle     = !p1v_ff && !p2v_ff && !p3v_ff;
      sts.clear_last    = (clr_ff == tpld_pkg::addr_type'(tpld_pkg::PLANE_BYTES - 1));
      sts.fill_empty    = (fy_ff > fhi_ff) || (fxl_ff > fxh_ff);
      sts.fill_last_row = (fy_ff == fhi_ff);
      sts.rsp_free      = !rsp_valid_ff || rsp_ready;
   end

endmodule

// File: rtl/core/two_plane_line_draw_engine.sv
// top level of the two-plane line draw engine
// depends on tpld_pkg, tpld_ctrl and tpld_datapath
//
// two-plane line draw engine: holds a black and a red bit plane of
// DISPLAY_WIDTH x DISPLAY_HEIGHT pixels, packed eight pixels to a byte with the
// leftmost pixel in the msb, in one on-chip memory of PLANE_BYTES words (one
// black byte and one red byte per word). a request draws a line (midpoint
// method), an outline rectangle (four lines), a filled rectangle (one span per
// row), clears both planes, or reads one byte of each plane back; only the
// read returns a response, and an index past the planes reads as zero. pixels
// off the display are dropped. the memory has one write port, so pixels go
// through a three-stage read-modify-write pipeline at one pixel per cycle while
// a line runs, with forwarding between neighbors. each line has setup steps
// (load, absolute differences, steep test, endpoint order), then steps along
// its major axis; the pipeline drains at the end of the request. an outline
// is four such lines, a fill one line per clipped row. a clear sweeps all
// PLANE_BYTES words (48000 at 800 x 480) one word a cycle. the same sweep runs
// after reset, and req_ready stays low until it is done. a finished read
// response waits in an output register while the next request is taken.

module two_plane_line_draw_engine (
   input  logic              clock,
   input  logic              reset,

   // request channel
   input  logic              req_valid,
   output logic              req_ready,
   input  tpld_pkg::req_type req_data,

   // response channel, read-back only
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tpld_pkg::rsp_type rsp_data
);

   tpld_pkg::cmd_type cmd;
   tpld_pkg::sts_type sts;

   // sequencer: decodes the request action, walks the setup steps of each
   // line, steps through outline edges and fill rows, and runs the clearing sweep
   tpld_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_ready  (req_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath: request latch, line stepper, clip and address stage,
   // plane memory with read-modify-write, and the response register
   tpld_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: sim/tpld_tb_pkg.sv
`timescale 1ns / 100ps
// bit-plane predictor and read-back checker for the two-plane line draw engine
// depends on tpld_pkg for geometry, action and ink codes and the payload types
package tpld_tb_pkg;
   import tpld_pkg::*;

   class plane_scoreboard;
      logic [BYTE_BITS-1:0] black_mem [PLANE_BYTES];
      logic [BYTE_BITS-1:0] red_mem   [PLANE_BYTES];
      rsp_type              pending_reads [$];
      int                   errors;

      function new();
         wipe();
         errors = 0;
      endfunction

      function void wipe();
         foreach (black_mem[i]) begin
            black_mem[i] = '0;
            red_mem[i]   = '0;
         end
      endfunction

      function int iabs(int v);
         return (v < 0) ? -v : v;
      endfunction

      function int to_coord(logic [COORD_BITS-1:0] v);
         return int'($signed(v));
      endfunction

      function void set_pixel(int x, int y, logic [1:0] ink);
         int                   idx;
         logic [BYTE_BITS-1:0] bitmask;
         if (x < 0 || x >= DISPLAY_WIDTH || y < 0 || y >= DISPLAY_HEIGHT) return;
         idx     = (y * DISPLAY_WIDTH + x) / BYTE_BITS;
         bitmask = 8'h80 >> (x % BYTE_BITS);
         case (ink)
            INK_BLACK: begin
               black_mem[idx] |= bitmask;
               red_mem[idx]   &= ~bitmask;
            end
            INK_RED: begin
               black_mem[idx] |= bitmask;
               red_mem[idx]   |= bitmask;
            end
            default: begin
               black_mem[idx] &= ~bitmask;
               red_mem[idx]   &= ~bitmask;
            end
         endcase
      endfunction

      // midpoint line, error term starts at half the major span
      function void trace_line(int ax, int ay, int bx, int by, logic [1:0] ink);
         bit steep;
         int t, dx, dy, err, ystep;
         steep = iabs(by - ay) > iabs(bx - ax);
         if (steep) begin
            t = ax; ax = ay; ay = t;
            t = bx; bx = by; by = t;
         end
         if (ax > bx) begin
            t = ax; ax = bx; bx = t;
            t = ay; ay = by; by = t;
         end
         dx    = bx - ax;
         dy    = iabs(by - ay);
         err   = dx / 2;
         ystep = (ay < by) ? 1 : -1;
         while (ax <= bx) begin
            if (steep) set_pixel(ay, ax, ink);
            else set_pixel(ax, ay, ink);
            err -= dy;
            if (err < 0) begin
               ay  += ystep;
               err += dx;
            end
            ax++;
         end
      endfunction

      function void fill_box(int ax, int ay, int bx, int by, logic [1:0] ink);
         int lo, hi, xl, xh;
         lo = (ay > by) ? by : ay;
         hi = (ay > by) ? ay : by;
         xl = (ax < bx) ? ax : bx;
         xh = (ax < bx) ? bx : ax;
         if (lo < 0) lo = 0;
         if (hi > DISPLAY_HEIGHT - 1) hi = DISPLAY_HEIGHT - 1;
         if (xl < 0) xl = 0;
         if (xh > DISPLAY_WIDTH - 1) xh = DISPLAY_WIDTH - 1;
         for (int y = lo; y <= hi; y++)
            for (int x = xl; x <= xh; x++)
               set_pixel(x, y, ink);
      endfunction

      // called once per accepted request, in acceptance order
      function void apply_request(req_type r);
         int      x0, y0, x1, y1;
         rsp_type want;
         x0 = to_coord(r.start_x);
         y0 = to_coord(r.start_y);
         x1 = to_coord(r.end_x);
         y1 = to_coord(r.end_y);
         case (r.action)
            ACT_LINE: trace_line(x0, y0, x1, y1, r.ink);
            ACT_RECT: begin
               trace_line(x0, y0, x0, y1, r.ink);
               trace_line(x0, y0, x1, y0, r.ink);
               trace_line(x1, y1, x0, y1, r.ink);
               trace_line(x1, y1, x1, y0, r.ink);
            end
            ACT_FILL: fill_box(x0, y0, x1, y1, r.ink);
            ACT_CLEAR: wipe();
            ACT_READ: begin
               want = '0;
               if (r.read_index < PLANE_BYTES) begin
                  want.black_byte = black_mem[r.read_index];
                  want.red_byte   = red_mem[r.read_index];
               end
               pending_reads.push_back(want);
            end
            default: ;
         endcase
      endfunction

      function void check_readback(rsp_type got);
         rsp_type want;
         if (pending_reads.size() == 0) begin
            $error("response with no read waiting: black_byte %h red_byte %h",
                   got.black_byte, got.red_byte);
            errors++;
            return;
         end
         want = pending_reads.pop_front();
         if (got.black_byte !== want.black_byte) begin
            $error("black_byte: expected %h, got %h", want.black_byte, got.black_byte);
            errors++;
         end
         if (got.red_byte !== want.red_byte) begin
            $error("red_byte: expected %h, got %h", want.red_byte, got.red_byte);
            errors++;
         end
      endfunction
   endclass

endpackage

// File: sim/tb_two_plane_line_draw_engine.sv
`timescale 1ns / 100ps
// top-level testbench for two_plane_line_draw_engine: drives requests, checks reads
// depends on tpld_pkg, tpld_tb_pkg and the engine rtl
module tb_two_plane_line_draw_engine;
   import tpld_pkg::*;
   import tpld_tb_pkg::*;

   // action codes the engine ignores
   localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;
   localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
   // both of these inks paint white
   localparam logic [1:0] INK_WHITE     = 2'd0;
   localparam logic [1:0] INK_WHITE_ALT = 2'd3;

   localparam int RANDOM_ITEMS    = 750;
   localparam int STEADY_FIRST    = 250;  // no idling on either side in this window
   localparam int STEADY_LAST     = 350;
   localparam int PRESSURE_AT     = 450;
   localparam int PRESSURE_READS  = 30;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES    = 200;
   // a clear sweep accepts nothing while it writes all 48000 words, this leaves room
   localparam int IDLE_LIMIT      = 150000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   bit steady_flow;
   bit hold_responses;
   int clears_left;
   int idle_cycles;

   plane_scoreboard books = new();

   two_plane_line_draw_engine u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly no gap or a short one, now and then a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 40) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 96) return $urandom_range(4, 16);
      return $urandom_range(20, 120);
   endfunction

   function automatic int byte_of(int x, int y);
      return (y * DISPLAY_WIDTH + x) / BYTE_BITS;
   endfunction

   function automatic req_type make_req(logic [2:0] action, int x0, int y0, int x1, int y1,
                                        logic [1:0] ink, int idx);
      req_type r;
      r.action     = action;
      r.start_x    = x0[COORD_BITS-1:0];
      r.start_y    = y0[COORD_BITS-1:0];
      r.end_x      = x1[COORD_BITS-1:0];
      r.end_y      = y1[COORD_BITS-1:0];
      r.ink        = ink;
      r.read_index = idx[15:0];
      return r;
   endfunction

   // two small windows where drawing and reads pile up: the top-left corner and
   // the bottom-right corner, both reaching a little past the display edges
   function automatic void hot_point(int region, output int x, output int y);
      if (region == 0) begin
         x = int'($urandom_range(0, 79)) - 8;
         y = int'($urandom_range(0, 39)) - 4;
      end else begin
         x = int'($urandom_range(752, 815));
         y = int'($urandom_range(448, 487));
      end
   endfunction

   function automatic req_type random_request();
      req_type     r;
      logic [95:0] noise;
      int          pick, region, x0, y0, x1, y1;
      noise  = {$urandom, $urandom, $urandom};
      r      = noise[$bits(req_type)-1:0];
      region = $urandom_range(0, 1);
      hot_point(region, x0, y0);
      hot_point(region, x1, y1);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         r.action = ACT_READ;
         pick = $urandom_range(0, 99);
         if (pick < 75) begin
            // a byte in the visible part of the window or just beside it
            if (region == 0)
               r.read_index = 16'(byte_of($urandom_range(0, 79), $urandom_range(0, 39)));
            else
               r.read_index = 16'(byte_of($urandom_range(752, 799),
                                          $urandom_range(448, 479)));
         end else if (pick < 90) begin
            r.read_index = 16'($urandom_range(0, PLANE_BYTES - 1));
         end
         // otherwise the raw 16-bit index stays, often past the planes
      end else if (pick < 64) begin
         // full-range lines keep the raw coordinates
         if ($urandom_range(0, 99) >= 15) r = make_req(ACT_LINE, x0, y0, x1, y1, r.ink,
                                                       r.read_index);
         else r.action = ACT_LINE;
      end else if (pick < 76) begin
         if ($urandom_range(0, 99) >= 5) r = make_req(ACT_RECT, x0, y0, x1, y1, r.ink,
                                                      r.read_index);
         else r.action = ACT_RECT;
      end else if (pick < 92) begin
         if ($urandom_range(0, 99) >= 12) begin
            r = make_req(ACT_FILL, x0, y0, x1, y1, r.ink, r.read_index);
         end else begin
            // wide span in x, at most a few rows on screen or none at all
            r.action = ACT_FILL;
            pick = $urandom_range(0, 2);
            if (pick == 0) begin
               y0 = int'($urandom_range(0, 481)) - 1;
               y1 = y0 + int'($urandom_range(0, 2)) - 1;
            end else if (pick == 1) begin
               y0 = -int'($urandom_range(1, 2048));
               y1 = -int'($urandom_range(1, 2048));
            end else begin
               y0 = $urandom_range(DISPLAY_HEIGHT, 2047);
               y1 = $urandom_range(DISPLAY_HEIGHT, 2047);
            end
            r.start_y = y0[COORD_BITS-1:0];
            r.end_y   = y1[COORD_BITS-1:0];
         end
      end else if (pick < 94 && clears_left > 0) begin
         // a clear costs a full memory sweep, so only a few of them
         clears_left--;
         r.action = ACT_CLEAR;
      end else if (pick < 94) begin
         r = make_req(ACT_LINE, x0, y0, x1, y1, r.ink, r.read_index);
      end else begin
         r.action = 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
      end
      return r;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance;
   // valid stays high when the next request follows with no gap
   task automatic send_request(input req_type r);
      int gap;
      gap = steady_flow ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (req_ready !== 1'b1);
      books.apply_request(r);
      @(negedge clock);
   endtask

   task automatic run_directed();
      // empty planes read as zero
      send_request(make_req(ACT_READ, 0, 0, 0, 0, INK_WHITE, 0));
      // corner to corner at the coordinate extremes, clipped to the visible diagonal
      send_request(make_req(ACT_LINE, -2048, -2048, 2047, 2047, INK_BLACK, 0));
      send_request(make_req(ACT_READ, 0, 0, 0, 0, INK_WHITE, 0));
      send_request(make_req(ACT_READ, 0, 0, 0, 0, INK_WHITE, byte_of(479, 479)));
      // steep line given bottom to top, so axes swap and endpoints swap
      send_request(make_req(ACT_LINE, 10, 40, 12, 2, INK_RED, 0));
      send_request(make_req(ACT_READ, 0, 0, 0, 0, INK_WHITE, byte_of(11, 20)));
      // single pixel in the last byte of the planes
      send_request(make_req(ACT_LINE, 799, 479, 799, 479, INK_RED, 0));
      send_request(make_req(ACT_READ, 0, 0, 0, 0, INK_WHITE, PLANE_BYTES - 1));
      // reads past the end of the planes return zero
      send_request(make_req(ACT_READ, 0, 0, 0, 0, INK_WHITE, PLANE_BYTES));
      send_request(make_req(ACT_READ, 0, 0, 0, 0, INK_WHITE, 16'hffff));
      // outlines with reversed corners, the second one painted white
      send_request(make_req(ACT_RECT, 30, 20, 5, 3, INK_BLACK, 0));
      send_request(make_req(ACT_RECT, 25, 15, 8, 6, INK_WHITE_ALT, 0));
      send_request(make_req(ACT_READ, 0, 0, 0, 0, INK_WHITE, byte_of(8, 6)));
      // two bottom rows over the full coordinate range in x
      send_request(make_req(ACT_FILL, 2047, 479, -2048, 478, INK_RED, 0));
      send_request(make_req(ACT_READ, 0, 0, 0, 0, INK_WHITE, byte_of(0, 478)));
      // fill with reversed corners, then punch a white hole into it
      send_request(make_req(ACT_FILL, 50, 10, 40, 4, INK_BLACK, 0));
      send_request(make_req(ACT_FILL, 45, 12, 43, 0, INK_WHITE, 0));
      send_request(make_req(ACT_READ, 0, 0, 0, 0, INK_WHITE, byte_of(40, 6)));
      // anti-diagonal at the extremes, it passes just beside the origin and stays off screen
      send_request(make_req(ACT_LINE, -2048, 2047, 2047, -2048, INK_RED, 0));
      send_request(make_req(ACT_READ, 0, 0, 0, 0, INK_WHITE, 0));
      // unused actions with every field bit set must change nothing
      for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
         send_request(make_req(a[2:0], -1, -1, -1, -1, INK_WHITE_ALT, 16'hffff));
      send_request(make_req(ACT_CLEAR, 0, 0, 0, 0, INK_WHITE, 0));
      send_request(make_req(ACT_READ, 0, 0, 0, 0, INK_WHITE, 0));
      send_request(make_req(ACT_READ, 0, 0, 0, 0, INK_WHITE, byte_of(0, 478)));
   endtask

   // response side: random ready pattern, one long hold-off on demand
   initial begin
      int span;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_responses) begin
            // long stall so the output register fills and the engine waits on the next read
            rsp_ready = 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            hold_responses = 1'b0;
         end else if (steady_flow || $urandom_range(0, 1) == 1) begin
            rsp_ready = 1'b1;
            span = $urandom_range(1, 24);
            repeat (span) @(negedge clock);
         end else begin
            rsp_ready = 1'b0;
            span = pick_gap() + 1;
            repeat (span) @(negedge clock);
         end
      end
   end

   // every accepted response goes against the oldest pending read
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1)
         books.check_readback(rsp_data);
   end

   // watchdog: cycles in a row with no request and no response accepted
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_two_plane_line_draw_engine NOT OK");
         $finish;
      end
   end

   initial begin
      req_type r;
      int      counted;
      bit      pressure_done;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      steady_flow    = 1'b0;
      hold_responses = 1'b0;
      clears_left    = 3;
      idle_cycles    = 0;
      counted        = 0;
      pressure_done  = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // ready stays low through the clearing sweep after reset; send_request waits it out
      run_directed();

      while (counted < RANDOM_ITEMS) begin
         steady_flow = (counted >= STEADY_FIRST && counted < STEADY_LAST);
         if (!pressure_done && counted >= PRESSURE_AT) begin
            // stall the response side and keep offering reads behind it
            pressure_done  = 1'b1;
            hold_responses = 1'b1;
            repeat (PRESSURE_READS) begin
               send_request(make_req(ACT_READ, 0, 0, 0, 0, INK_WHITE,
                                     byte_of($urandom_range(0, 79), $urandom_range(0, 39))));
               counted++;
            end
         end
         r = random_request();
         send_request(r);
         // requests the engine ignores do not count
         if (r.action <= ACT_READ) counted++;
      end
      steady_flow = 1'b0;

      // a last read: once it is back, every earlier request has finished
      send_request(make_req(ACT_READ, 0, 0, 0, 0, INK_WHITE, byte_of(0, 0)));
      req_valid = 1'b0;

      while (books.pending_reads.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (books.errors == 0 && books.pending_reads.size() == 0)
         $display("tb_two_plane_line_draw_engine OK");
      else
         $display("tb_two_plane_line_draw_engine NOT OK");
      $finish;
   end

endmodule
